// ----- design/rcfn_pkg.sv -----
// Shared types, codes and saturation helper for the oversampled RC filter network.
// No dependencies; used by rcfn_mac and the filter network top level.
`default_nettype none

package rcfn_pkg;

  // Sample and coefficient widths
  localparam int SAMPLE_W = 16;
  localparam int OP_W     = 18;
  localparam int PROD_W   = 36;
  localparam int SUM_W    = 37;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_FEEDBACK = 3'd1;
  localparam logic [2:0] REG_INPUT    = 3'd2;
  localparam logic [2:0] REG_HPGAIN   = 3'd3;
  localparam logic [2:0] REG_RESON    = 3'd4;

  // Mode codes
  localparam logic [2:0] MODE_LP12 = 3'd0;
  localparam logic [2:0] MODE_BP12 = 3'd1;
  localparam logic [2:0] MODE_HP12 = 3'd2;
  localparam logic [2:0] MODE_LP24 = 3'd3;
  localparam logic [2:0] MODE_BP24 = 3'd4;
  localparam logic [2:0] MODE_HP24 = 3'd5;

  // Output kind codes
  localparam logic [1:0] KIND_LP = 2'd0;
  localparam logic [1:0] KIND_BP = 2'd1;
  localparam logic [1:0] KIND_HP = 2'd2;

  // Oversampling passes per input sample
  localparam int PASSES = 4;
  localparam int PASS_W = 2;

  // Saturation limits, +-1.0 in Q2.14
  localparam logic signed [SUM_W-1:0] UNITY_POS = 37'sd16384;
  localparam logic signed [SUM_W-1:0] UNITY_NEG = -37'sd16384;

  typedef logic signed [SAMPLE_W-1:0] audio_t;
  typedef logic signed [OP_W-1:0]     operand_t;
  typedef logic signed [PROD_W-1:0]   product_t;
  typedef logic signed [SUM_W-1:0]    wide_t;

  // Clamp a wide sum to +-1.0
  function automatic audio_t sat(input wide_t v);
    audio_t r;
    if (v > UNITY_POS) begin
      r = 16'sd16384;
    end else if (v < UNITY_NEG) begin
      r = -16'sd16384;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/rcfn_mac.sv -----
// Shared signed multiplier with a registered product.
// Depends on rcfn_pkg for operand and product types.
`default_nettype none

module rcfn_mac (
  input  wire logic               clk,
  input  wire rcfn_pkg::operand_t op_a,
  input  wire rcfn_pkg::operand_t op_b,
  output rcfn_pkg::product_t      prod
);

  // Register the product for the next sequencer step
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

`default_nettype wire

// ----- design/rc_filter_network_oversampled_unit.sv -----
// Top level of the oversampled saturating RC filter network (12/24 dB).
// Depends on rcfn_pkg and rcfn_mac.
//
//   channel   dir  beat fields (lowest bit up)
//   s_*       in   tdata: sample_in[15:0]; tuser: channel[0]
//   m_*       out  tdata: sample_out[15:0]
//   cfg_*     in   cfg_index[2:0] register index, cfg_data[15:0] value
//
// From accept to result a sample runs through seven sequencer steps per stage
// pass around the single shared multiplier, four passes, one or two stages per
// pass (12 or 24 dB modes), plus a step that loads the output. The block takes
// the next sample only after that load, so samples never overlap in work.
// Reset (rst, synchronous) clears all filter state and loads register defaults.
// s_tready is low while a sample is in work; a result held by m_tready low
// stalls the block only when the next result is ready to load.
`default_nettype none

module rc_filter_network_oversampled_unit #(
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // sample_in[15:0]
  input  wire logic [0:0]  s_tuser,   // channel[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // sample_out[15:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_Q, S_IN, S_LP0, S_LP1, S_HP, S_BP0, S_BP1, S_FIN
  } state_t;

  state_t state;

  // Configuration registers
  logic [2:0]  mode;
  logic [15:0] feedback_coeff;
  logic [15:0] input_coeff;
  logic [15:0] highpass_gain;
  logic [15:0] resonance;

  // Filter state, per stage and channel
  rcfn_pkg::audio_t st_lp   [2][NUM_CHANNELS];
  rcfn_pkg::audio_t st_hp   [2][NUM_CHANNELS];
  rcfn_pkg::audio_t st_bp   [2][NUM_CHANNELS];
  rcfn_pkg::audio_t st_prev [2][NUM_CHANNELS];

  // Working registers
  logic                            stg;
  logic [rcfn_pkg::PASS_W-1:0]     pass;
  logic [CH_W-1:0]                 ch;
  rcfn_pkg::audio_t                sample;
  rcfn_pkg::audio_t                in_reg;
  rcfn_pkg::product_t              acc;

  rcfn_pkg::operand_t op_a;
  rcfn_pkg::operand_t op_b;
  rcfn_pkg::product_t prod;

  logic              two_stage;
  logic [1:0]        kind;
  logic [CH_W-1:0]   ch_sel;
  rcfn_pkg::audio_t  cur_lp, cur_hp, cur_bp, cur_prev;
  rcfn_pkg::audio_t  x_in;
  rcfn_pkg::audio_t  in_val, lp_val, hp_val, bp_val;
  rcfn_pkg::audio_t  result;
  rcfn_pkg::operand_t hp_diff;
  rcfn_pkg::wide_t   q_term;
  rcfn_pkg::wide_t   acc_sum;

  function automatic rcfn_pkg::audio_t pick(input logic [1:0] k,
                                            input rcfn_pkg::audio_t lp,
                                            input rcfn_pkg::audio_t bp,
                                            input rcfn_pkg::audio_t hp);
    rcfn_pkg::audio_t r;
    if (k == rcfn_pkg::KIND_LP) begin
      r = lp;
    end else if (k == rcfn_pkg::KIND_BP) begin
      r = bp;
    end else begin
      r = hp;
    end
    return r;
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign ch_sel    = (NUM_CHANNELS > 1) ? CH_W'(s_tuser[0]) : '0;

  // Decode mode; unused codes act as hp24
  always_comb begin
    unique case (mode)
      rcfn_pkg::MODE_LP12: begin two_stage = 1'b0; kind = rcfn_pkg::KIND_LP; end
      rcfn_pkg::MODE_BP12: begin two_stage = 1'b0; kind = rcfn_pkg::KIND_BP; end
      rcfn_pkg::MODE_HP12: begin two_stage = 1'b0; kind = rcfn_pkg::KIND_HP; end
      rcfn_pkg::MODE_LP24: begin two_stage = 1'b1; kind = rcfn_pkg::KIND_LP; end
      rcfn_pkg::MODE_BP24: begin two_stage = 1'b1; kind = rcfn_pkg::KIND_BP; end
      default:             begin two_stage = 1'b1; kind = rcfn_pkg::KIND_HP; end
    endcase
  end

  // Current stage state and stage input
  assign cur_lp   = st_lp[stg][ch];
  assign cur_hp   = st_hp[stg][ch];
  assign cur_bp   = st_bp[stg][ch];
  assign cur_prev = st_prev[stg][ch];
  assign x_in     = stg ? pick(kind, st_lp[0][ch], st_bp[0][ch], st_hp[0][ch]) : sample;
  assign result   = two_stage ? pick(kind, st_lp[1][ch], st_bp[1][ch], st_hp[1][ch])
                              : pick(kind, st_lp[0][ch], st_bp[0][ch], st_hp[0][ch]);

  // Round, add and clamp on the product register
  assign hp_diff = rcfn_pkg::OP_W'(cur_hp) + rcfn_pkg::OP_W'(in_reg)
                 - rcfn_pkg::OP_W'(cur_prev);
  assign q_term  = (rcfn_pkg::SUM_W'(prod) + 37'sd2048) >>> 12;
  assign acc_sum = rcfn_pkg::SUM_W'(acc) + rcfn_pkg::SUM_W'(prod);
  assign in_val  = rcfn_pkg::sat(q_term + rcfn_pkg::SUM_W'(x_in));
  assign lp_val  = rcfn_pkg::sat((acc_sum + 37'sd16384) >>> 15);
  assign bp_val  = lp_val;
  assign hp_val  = rcfn_pkg::sat((rcfn_pkg::SUM_W'(prod) + 37'sd16384) >>> 15);

  // Select multiplier operands for this step
  always_comb begin
    unique case (state)
      S_Q: begin
        op_a = rcfn_pkg::OP_W'(cur_bp);
        op_b = $signed({2'b00, resonance});
      end
      S_IN: begin
        op_a = rcfn_pkg::OP_W'(cur_lp);
        op_b = $signed({2'b00, feedback_coeff});
      end
      S_LP0: begin
        op_a = rcfn_pkg::OP_W'(in_reg);
        op_b = $signed({2'b00, input_coeff});
      end
      S_LP1: begin
        op_a = hp_diff;
        op_b = $signed({2'b00, highpass_gain});
      end
      S_HP: begin
        op_a = rcfn_pkg::OP_W'(cur_bp);
        op_b = $signed({2'b00, feedback_coeff});
      end
      S_BP0: begin
        op_a = rcfn_pkg::OP_W'(cur_hp);
        op_b = $signed({2'b00, input_coeff});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  rcfn_mac u_mac (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= 3'd0;
      feedback_coeff <= 16'd0;
      input_coeff    <= 16'd32768;
      highpass_gain  <= 16'd0;
      resonance      <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcfn_pkg::REG_MODE:     mode           <= cfg_data[2:0];
        rcfn_pkg::REG_FEEDBACK: feedback_coeff <= cfg_data;
        rcfn_pkg::REG_INPUT:    input_coeff    <= cfg_data;
        rcfn_pkg::REG_HPGAIN:   highpass_gain  <= cfg_data;
        rcfn_pkg::REG_RESON:    resonance      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      stg      <= 1'b0;
      pass     <= '0;
      ch       <= '0;
      m_tvalid <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          st_lp[s][c]   <= '0;
          st_hp[s][c]   <= '0;
          st_bp[s][c]   <= '0;
          st_prev[s][c] <= '0;
        end
      end
    end else begin
      // drop the output beat once taken, unless the next one loads now
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sample <= $signed(s_tdata);
            ch     <= ch_sel;
            stg    <= 1'b0;
            pass   <= '0;
            state  <= S_Q;
          end
        end
        S_Q: begin
          state <= S_IN;
        end
        S_IN: begin
          in_reg <= in_val;
          state  <= S_LP0;
        end
        S_LP0: begin
          acc   <= prod;
          state <= S_LP1;
        end
        S_LP1: begin
          st_lp[stg][ch] <= lp_val;
          state          <= S_HP;
        end
        S_HP: begin
          st_hp[stg][ch]   <= hp_val;
          st_prev[stg][ch] <= in_reg;
          state            <= S_BP0;
        end
        S_BP0: begin
          acc   <= prod;
          state <= S_BP1;
        end
        S_BP1: begin
          st_bp[stg][ch] <= bp_val;
          // advance to the next stage or pass
          if (two_stage && !stg) begin
            stg   <= 1'b1;
            state <= S_Q;
          end else if (pass == rcfn_pkg::PASS_W'(rcfn_pkg::PASSES - 1)) begin
            state <= S_FIN;
          end else begin
            stg   <= 1'b0;
            pass  <= pass + 1'b1;
            state <= S_Q;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= result;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/rcfn_checker.sv -----
// Port-level assertions for the RC filter network top level, with its bind.
// Depends on rc_filter_network_oversampled_unit port names only.
`default_nettype none

module rcfn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // Results stay within +-1.0
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata) <= 16'sd16384) && ($signed(m_tdata) >= -16'sd16384))
    else $error("output sample outside +-1.0");

  // Block stays busy after taking a sample
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("input accepted while a sample is in work");

  // No result appears right after an accept
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

endmodule

bind rc_filter_network_oversampled_unit rcfn_checker u_rcfn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
